// ----- rtl/core/line_buffer_upcase_echo_top_assert.svh -----
// Assertion macros for the line buffer with upper-case echo.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LINE_BUFFER_UPCASE_ECHO_TOP_ASSERT_SVH
`define LINE_BUFFER_UPCASE_ECHO_TOP_ASSERT_SVH

// Same-cycle implication.
`define LBUE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line buffer assertion failed");

// Next-cycle implication.
`define LBUE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line buffer assertion failed");

`endif

// ----- rtl/core/lbue_pkg.sv -----
// ----------------------------------------------------------------------------
// lbue_pkg
// Shared types and character constants for the line buffer with upper-case
// echo.
// ----------------------------------------------------------------------------
`default_nettype none

package lbue_pkg;

    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_DELTA = 8'h20;  // 'a' - 'A'

    // One classified word handed from the front to the back
    typedef struct packed {
        logic       eol;         // line feed or carriage return
        logic [7:0] echo_byte;   // byte as received
        logic [7:0] store_byte;  // byte raised to upper case
    } lbue_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/lbue_front.sv -----
// ----------------------------------------------------------------------------
// lbue_front
// Accepts received bytes, classifies them as line end or ordinary, raises
// lower-case letters, and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbue_front
    import lbue_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic           cmd_valid,
    input  wire logic      cmd_ready,
    output lbue_cmd_t      cmd
);

    lbue_cmd_t  q_reg [2];
    logic       wr_idx_reg, wr_idx_next;
    logic       rd_idx_reg, rd_idx_next;
    logic [1:0] cnt_reg, cnt_next;
    lbue_cmd_t  cls;
    logic       push;
    logic       pop;

    // Classify the incoming word
    always_comb
    begin
        cls.eol        = (s_tdata == CH_LF) || (s_tdata == CH_CR);
        cls.echo_byte  = s_tdata;
        cls.store_byte = s_tdata;
        if ((s_tdata >= CH_LOWER_A) && (s_tdata <= CH_LOWER_Z))
        begin
            cls.store_byte = s_tdata - CASE_DELTA;
        end
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_idx_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue pointers and count
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_idx_next = ~wr_idx_reg;
        end
        if (pop)
        begin
            rd_idx_next = ~rd_idx_reg;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_idx_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lbue_back.sv -----
// ----------------------------------------------------------------------------
// lbue_back
// Carries out commands: echoes ordinary bytes and stores them in the circular
// line FIFO; on a line end emits LF CR, drains the FIFO one byte a cycle when
// the output is free, then LF CR again. Results leave via an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbue_back
    import lbue_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire lbue_cmd_t  cmd,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] tx_byte
    output logic            m_tlast
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CR1   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_LF2   = 5'b01000,
        ST_CR2   = 5'b10000
    } lbue_state_t;

    lbue_state_t       state_reg, state_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic              out_free;
    logic [7:0]        mem [DEPTH];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Sequencer: one result per cycle while the output register is free and work is pending
    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        if (out_free)
        begin
            out_valid_next = 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_ready      = 1'b1;
                        out_valid_next = 1'b1;
                        if (cmd.eol)
                        begin
                            out_data_next = CH_LF;
                            out_last_next = 1'b0;
                            state_next    = ST_CR1;
                        end
                        else
                        begin
                            out_data_next = cmd.echo_byte;
                            out_last_next = 1'b1;
                            // full FIFO drops the byte
                            if (fill_reg < FILL_W'(DEPTH))
                            begin
                                mem_we      = 1'b1;
                                wr_ptr_next = ptr_inc(wr_ptr_reg);
                                fill_next   = fill_reg + FILL_W'(1);
                            end
                        end
                    end
                end
                ST_CR1:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = CH_CR;
                    out_last_next  = 1'b0;
                    state_next     = (fill_reg != '0) ? ST_DRAIN : ST_LF2;
                end
                ST_DRAIN:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data_reg;
                    out_last_next  = 1'b0;
                    rd_ptr_next    = ptr_inc(rd_ptr_reg);
                    fill_next      = fill_reg - FILL_W'(1);
                    if (fill_reg == FILL_W'(1))
                    begin
                        state_next = ST_LF2;
                    end
                end
                ST_LF2:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = CH_LF;
                    out_last_next  = 1'b0;
                    state_next     = ST_CR2;
                end
                ST_CR2:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = CH_CR;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Line FIFO memory; read port prefetches the entry at the next read pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= cmd.store_byte;
        end
        rd_data_reg <= mem[rd_ptr_next];
    end

endmodule

`default_nettype wire

// ----- rtl/core/line_buffer_upcase_echo_top.sv -----
// Path: a taken input word passes the command queue, then the output register,
// before it shows on m_tvalid. Throughput: ordinary bytes sustain one word per
// cycle while m_tready is high; a line end holds the back end for LF, CR, the
// FIFO bytes one a cycle, LF, CR. A two-word command queue lets the input keep
// taking words meanwhile. Reset (rst_n low, async): queue, FIFO pointers and
// output valid clear; FIFO contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// line_buffer_upcase_echo_top
// Line buffer that echoes each byte and replays the buffered line in upper
// case on a line end.
// ----------------------------------------------------------------------------
`default_nettype none

module line_buffer_upcase_echo_top
    import lbue_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] tx_byte
    output logic            m_tlast
);

    logic      cmd_valid;
    logic      cmd_ready;
    lbue_cmd_t cmd;

    // Front: classify and queue
    lbue_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: echo, store, drain
    lbue_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/lbue_checker.sv -----
// ----------------------------------------------------------------------------
// lbue_checker
// Port-level checks on the output stream of the line buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_buffer_upcase_echo_top_assert.svh"

module lbue_checker
    import lbue_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // A stalled word holds
    `LBUE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // LF is always followed at once by CR
    `LBUE_ASSERT_NEXT(a_lf_then_cr, m_tvalid && m_tready && (m_tdata == CH_LF), m_tvalid && (m_tdata == CH_CR))

    // LF never ends a run
    `LBUE_ASSERT_IMPL(a_lf_not_last, m_tvalid && (m_tdata == CH_LF), !m_tlast)

endmodule

bind line_buffer_upcase_echo_top lbue_checker u_lbue_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
